### src/triv_pkg.sv
// ----------------------------------------------------------------------------
// triv_pkg
// Shared types, constants and helpers for the Trivium keystream block.
// ----------------------------------------------------------------------------
package triv_pkg;

  // State geometry: 36 cells of 8 bits, 288 state bits in total
  localparam int unsigned CELL_W     = 8;
  localparam int unsigned NUM_CELLS  = 36;
  localparam int unsigned STATE_W    = CELL_W * NUM_CELLS;

  // Key / IV geometry
  localparam int unsigned KEY_W      = 80;
  localparam int unsigned IV_BASE    = 93;
  localparam int unsigned ONES_BASE  = 285;

  // Feedback injection points after the shift
  localparam int unsigned T1_POS     = 93;
  localparam int unsigned T2_POS     = 177;
  localparam int unsigned T1_CELL    = T1_POS / CELL_W;
  localparam int unsigned T2_CELL    = T2_POS / CELL_W;

  // Round counts
  localparam int unsigned INIT_ROUNDS      = 4 * 288;
  localparam int unsigned BITS_PER_REQUEST = 8;
  localparam int unsigned CNT_W            = $clog2(INIT_ROUNDS);

  // Request kinds carried on in_tuser
  typedef enum logic [1:0] {
    REQ_INIT = 2'd0,
    REQ_BYTE = 2'd1,
    REQ_ADV  = 2'd2
  } triv_req_t;

  // Configuration register indexes
  localparam logic CFG_KEY_LOW  = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  // Control sweep handed to every cell
  typedef struct packed {
    logic load;
    logic shift;
  } triv_cell_ctl_t;

  // Round feedback: keystream bit and the three new state bits
  typedef struct packed {
    logic z;
    logic t1;
    logic t2;
    logic t3;
  } triv_fb_t;

  // Control FSM, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } triv_state_t;

  // State bit j takes value bit 79-j
  function automatic logic [KEY_W-1:0] rev80(input logic [KEY_W-1:0] v);
    logic [KEY_W-1:0] r;
    for (int j = 0; j < KEY_W; j++) begin
      r[j] = v[KEY_W-1-j];
    end
    return r;
  endfunction

  // Injection mask for one cell
  function automatic logic [CELL_W-1:0] inj_mask(input int unsigned idx);
    logic [CELL_W-1:0] m;
    m = '0;
    if (idx == T1_CELL) m[T1_POS % CELL_W] = 1'b1;
    if (idx == T2_CELL) m[T2_POS % CELL_W] = 1'b1;
    return m;
  endfunction

endpackage

### src/triv_cell.sv
// ----------------------------------------------------------------------------
// triv_cell
// One byte of the shift state: parallel load, shift by one with carry from
// the lower neighbor, and optional overwrite of one bit with feedback.
// ----------------------------------------------------------------------------
module triv_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  triv_pkg::triv_cell_ctl_t          ctl,
  input  logic [triv_pkg::CELL_W-1:0]       load_val,
  input  logic                              carry_in,
  input  logic [triv_pkg::CELL_W-1:0]       mask,
  input  logic                              inj_bit,
  output logic [triv_pkg::CELL_W-1:0]       q
);

  logic [triv_pkg::CELL_W-1:0] q_r;
  logic [triv_pkg::CELL_W-1:0] shifted;

  // shift up, then drop the feedback bit in where the mask says
  assign shifted = ({q_r[triv_pkg::CELL_W-2:0], carry_in} & ~mask)
                 | (mask & {triv_pkg::CELL_W{inj_bit}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (ctl.load) begin
      q_r <= load_val;
    end else if (ctl.shift) begin
      q_r <= shifted;
    end
  end

  assign q = q_r;

endmodule

### src/triv_round.sv
// ----------------------------------------------------------------------------
// triv_round
// Nonlinear feedback of one Trivium round taken from the full state.
// ----------------------------------------------------------------------------
module triv_round (
  input  logic [triv_pkg::STATE_W-1:0] s,
  output triv_pkg::triv_fb_t           fb
);

  logic a1, a2, a3;

  // linear parts also form the keystream bit
  assign a1 = s[65]  ^ s[92];
  assign a2 = s[161] ^ s[176];
  assign a3 = s[242] ^ s[287];

  assign fb.z  = a1 ^ a2 ^ a3;
  assign fb.t1 = a1 ^ (s[90]  & s[91])  ^ s[170];
  assign fb.t2 = a2 ^ (s[174] & s[175]) ^ s[263];
  assign fb.t3 = a3 ^ (s[285] & s[286]) ^ s[68];

endmodule

### src/trivium_keystream_cipher_top.sv
// Init runs all initialisation rounds; a byte result is registered from its
//   last round; advance runs one round. One round per cycle in the cell chain
//   while a request runs; a new item is taken only in idle, never in hold.
// A finished byte waits in the output register while the next item runs, or in hold.
// Reset (rst_n, synchronous): state, key and output valid cleared.
// ----------------------------------------------------------------------------
// trivium_keystream_cipher_top
// Trivium stream cipher, 80-bit key and IV, 288-bit state held in a chain
// of 36 byte cells that shift one bit per cycle while a request runs.
// ----------------------------------------------------------------------------
module trivium_keystream_cipher_top (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [63:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // iv_low[63:0], iv_high[79:64], data_in[87:80]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // data_out[7:0]
);

  localparam int unsigned CW = triv_pkg::CELL_W;
  localparam int unsigned NC = triv_pkg::NUM_CELLS;
  localparam int unsigned SW = triv_pkg::STATE_W;
  localparam int unsigned KW = triv_pkg::KEY_W;

  logic [63:0]                 key_low_r;
  logic [15:0]                 key_high_r;
  triv_pkg::triv_state_t       state_r;
  logic [triv_pkg::CNT_W-1:0]  cnt_r;
  logic [triv_pkg::CNT_W-1:0]  last_r;
  logic                        is_byte_r;
  logic [7:0]                  din_r;
  logic [7:0]                  ks_r;
  logic [7:0]                  ks_nxt;
  logic                        out_valid_r;
  logic [7:0]                  out_data_r;

  logic [SW-1:0]               s;
  logic [SW-1:0]               ld_vec;
  triv_pkg::triv_fb_t          fb;
  triv_pkg::triv_cell_ctl_t    cell_ctl;
  logic                        in_acc;
  logic                        out_free;
  logic                        last_round;
  logic                        out_load;
  logic [7:0]                  out_ks;

  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign last_round = (cnt_r == last_r);
  assign in_tready  = (state_r == triv_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        triv_pkg::CFG_KEY_LOW:  key_low_r  <= cfg_wdata;
        triv_pkg::CFG_KEY_HIGH: key_high_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // init image: key, IV, three ones at the top
  always_comb begin
    ld_vec = '0;
    ld_vec[KW-1:0] = triv_pkg::rev80({key_high_r, key_low_r});
    ld_vec[triv_pkg::IV_BASE +: KW] = triv_pkg::rev80(in_tdata[79:0]);
    ld_vec[SW-1:triv_pkg::ONES_BASE] = '1;
  end

  // cell control
  always_comb begin
    cell_ctl.load  = in_acc && (in_tuser == triv_pkg::REQ_INIT);
    cell_ctl.shift = (state_r == triv_pkg::ST_RUN);
  end

  // chain of cells
  for (genvar i = 0; i < NC; i++) begin : g_cell
    logic cin;
    logic inj;
    if (i == 0) begin : g_first
      assign cin = fb.t3;
    end else begin : g_rest
      assign cin = s[CW*i-1];
    end
    if (i == triv_pkg::T1_CELL) begin : g_t1
      assign inj = fb.t1;
    end else if (i == triv_pkg::T2_CELL) begin : g_t2
      assign inj = fb.t2;
    end else begin : g_none
      assign inj = 1'b0;
    end
    triv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl),
      .load_val (ld_vec[CW*i +: CW]),
      .carry_in (cin),
      .mask     (triv_pkg::inj_mask(i)),
      .inj_bit  (inj),
      .q        (s[CW*i +: CW])
    );
  end

  triv_round u_round (
    .s  (s),
    .fb (fb)
  );

  // keystream byte with this round's bit folded in
  always_comb begin
    ks_nxt = ks_r;
    if (cnt_r < triv_pkg::CNT_W'(8)) begin
      ks_nxt = ks_r | (8'(fb.z) << cnt_r[2:0]);
    end
  end

  // a finished byte enters the output register from the last round or from hold
  assign out_load = out_free &&
                    ((state_r == triv_pkg::ST_RUN && last_round && is_byte_r) ||
                     state_r == triv_pkg::ST_HOLD);
  assign out_ks   = (state_r == triv_pkg::ST_HOLD) ? ks_r : ks_nxt;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
      out_data_r  <= din_r ^ out_ks;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= triv_pkg::ST_IDLE;
      cnt_r       <= '0;
      last_r      <= '0;
      is_byte_r   <= 1'b0;
    end else begin
      unique case (state_r)
        triv_pkg::ST_IDLE: begin
          if (in_acc) begin
            cnt_r <= '0;
            ks_r  <= '0;
            din_r <= in_tdata[87:80];
            case (in_tuser)
              triv_pkg::REQ_INIT: begin
                last_r    <= triv_pkg::CNT_W'(triv_pkg::INIT_ROUNDS - 1);
                is_byte_r <= 1'b0;
                state_r   <= triv_pkg::ST_RUN;
              end
              triv_pkg::REQ_BYTE: begin
                last_r    <= triv_pkg::CNT_W'(triv_pkg::BITS_PER_REQUEST - 1);
                is_byte_r <= 1'b1;
                state_r   <= triv_pkg::ST_RUN;
              end
              triv_pkg::REQ_ADV: begin
                last_r    <= '0;
                is_byte_r <= 1'b0;
                state_r   <= triv_pkg::ST_RUN;
              end
              default: ;  // unused code: dropped
            endcase
          end
        end
        triv_pkg::ST_RUN: begin
          cnt_r <= cnt_r + 1'b1;
          ks_r  <= ks_nxt;
          if (last_round) begin
            if (!is_byte_r || out_free) begin
              state_r <= triv_pkg::ST_IDLE;
            end else begin
              state_r <= triv_pkg::ST_HOLD;
            end
          end
        end
        triv_pkg::ST_HOLD: begin
          if (out_free) begin
            state_r <= triv_pkg::ST_IDLE;
          end
        end
        default: state_r <= triv_pkg::ST_IDLE;
      endcase
    end
  end

  // checks
  a_hold_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == triv_pkg::ST_HOLD |-> out_valid_r)
    else $error("hold state without a pending word");

  a_out_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == triv_pkg::ST_RUN ||
                                 state_r == triv_pkg::ST_HOLD))
    else $error("result word appeared without a run");

  a_init_runs: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser == triv_pkg::REQ_INIT |=> state_r == triv_pkg::ST_RUN &&
      cnt_r == '0)
    else $error("init did not start the round sequence");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == triv_pkg::ST_RUN |-> cnt_r <= last_r)
    else $error("round counter past its limit");

endmodule

### dv/trivium_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trivium_stream_checker
// Passive checker for the Trivium keystream block. It follows key writes and
// accepted request words, keeps its own 288-bit cipher state, predicts every
// encrypted byte and compares each result word with the oldest prediction.
// ----------------------------------------------------------------------------
module trivium_stream_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [63:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [87:0] in_tdata,   // iv_low[63:0], iv_high[79:64], data_in[87:80]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // data_out[7:0]
  output int unsigned errors,
  output int unsigned pending
);

  logic [triv_pkg::KEY_W-1:0]   key_value;      // {key_high, key_low}
  logic [triv_pkg::STATE_W-1:0] cipher_bits;    // bit j is state bit j
  logic [7:0]                   expected_bytes[$];
  int unsigned                  error_count = 0;
  int unsigned                  backlog = 0;

  assign errors  = error_count;
  assign pending = backlog;

  // one round of the cipher; returns the keystream bit
  function automatic logic cipher_round();
    logic t1, t2, t3, z;
    t1 = cipher_bits[65] ^ cipher_bits[92];
    t2 = cipher_bits[161] ^ cipher_bits[176];
    t3 = cipher_bits[242] ^ cipher_bits[287];
    z  = t1 ^ t2 ^ t3;
    t1 ^= (cipher_bits[90] & cipher_bits[91]) ^ cipher_bits[170];
    t2 ^= (cipher_bits[174] & cipher_bits[175]) ^ cipher_bits[263];
    t3 ^= (cipher_bits[285] & cipher_bits[286]) ^ cipher_bits[68];
    cipher_bits      = {cipher_bits[triv_pkg::STATE_W-2:0], t3};
    cipher_bits[93]  = t1;
    cipher_bits[177] = t2;
    return z;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t ERROR %s: got 0x%02h, want 0x%02h", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : watch
    logic [7:0]                 ks;
    logic [triv_pkg::KEY_W-1:0] iv;
    logic                       z;
    if (!rst_n) begin
      key_value   = '0;
      cipher_bits = '0;
      expected_bytes.delete();
    end else begin
      // result side first: it always belongs to an earlier request
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("result word with nothing expected", out_tdata, 8'hxx);
        end else if (out_tdata !== expected_bytes[0]) begin
          report_mismatch("data_out", out_tdata, expected_bytes[0]);
          void'(expected_bytes.pop_front());
        end else begin
          void'(expected_bytes.pop_front());
        end
      end

      // key registers
      if (cfg_we) begin
        if (cfg_addr == triv_pkg::CFG_KEY_LOW) key_value[63:0] = cfg_wdata;
        else key_value[79:64] = cfg_wdata[15:0];
      end

      // request words
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          triv_pkg::REQ_INIT: begin
            iv          = in_tdata[79:0];
            cipher_bits = '0;
            for (int j = 0; j < triv_pkg::KEY_W; j++) begin
              cipher_bits[j]                     = key_value[triv_pkg::KEY_W-1-j];
              cipher_bits[triv_pkg::IV_BASE + j] = iv[triv_pkg::KEY_W-1-j];
            end
            cipher_bits[287:285] = 3'b111;
            for (int r = 0; r < triv_pkg::INIT_ROUNDS; r++) void'(cipher_round());
          end
          triv_pkg::REQ_BYTE: begin
            ks = '0;
            for (int k = 0; k < triv_pkg::BITS_PER_REQUEST; k++) begin
              z = cipher_round();
              if (k < 8) ks[k] = z;
            end
            expected_bytes.push_back(in_tdata[87:80] ^ ks);
          end
          triv_pkg::REQ_ADV: void'(cipher_round());
          default: ; // unused code: no effect
        endcase
      end
    end
    backlog <= expected_bytes.size();
  end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the Trivium keystream block: directed requests
// around reset and key changes, then random init/byte/advance sessions under
// several keys, with random gaps on both streams and long result stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned GAP_MAX        = 18;
  localparam int unsigned HOLD_CYCLES    = 2000;
  localparam int unsigned WATCHDOG_LIMIT = 10000;
  localparam int unsigned DRAIN_CYCLES   = triv_pkg::INIT_ROUNDS + 48;
  localparam int unsigned RANDOM_ITEMS   = 480;
  localparam logic [1:0]  REQ_UNUSED     = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_addr;
  logic [63:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;    // iv_low[63:0], iv_high[79:64], data_in[87:80]
  logic [1:0]  in_tuser;    // req_type[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;   // data_out[7:0]
  int unsigned errors;
  int unsigned pending;
  int unsigned sent = 0;
  int unsigned idle_cycles = 0;

  always #6 clk = ~clk;

  trivium_keystream_cipher_top dut (.*);
  trivium_stream_checker checker_i (.*);

  // watchdog: cycles without any word moving on either stream
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("trivium_keystream_cipher_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, quiet stretches, and long hold-offs
  initial begin : drain
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      taken++;
      if (taken % 200 == 40) stall = HOLD_CYCLES;
      else if ((taken / 50) % 3 == 2) stall = 0;
      else stall = $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  function automatic logic [triv_pkg::KEY_W-1:0] rand80();
    logic [95:0] r;
    r = {$urandom, $urandom, $urandom};
    return r[triv_pkg::KEY_W-1:0];
  endfunction

  // offer one request word after a random gap, return once accepted
  task automatic send_word(input logic [1:0] kind,
                           input logic [triv_pkg::KEY_W-1:0] iv,
                           input logic [7:0] data);
    int unsigned gap;
    gap = ((sent / 40) % 4 == 3) ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {data, iv};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // wait for every byte, then for a full init to drain out
  task automatic quiesce();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_key(input logic [triv_pkg::KEY_W-1:0] key);
    cfg_we    <= 1'b1;
    cfg_addr  <= triv_pkg::CFG_KEY_LOW;
    cfg_wdata <= key[63:0];
    @(posedge clk);
    cfg_addr  <= triv_pkg::CFG_KEY_HIGH;
    cfg_wdata <= {48'd0, key[79:64]};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    logic [triv_pkg::KEY_W-1:0] phase_key[4];
    logic [triv_pkg::KEY_W-1:0] iv;
    logic [1:0]                 kind;
    int unsigned                n;
    int unsigned                len;
    int unsigned                pick;

    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= triv_pkg::CFG_KEY_LOW;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= triv_pkg::REQ_INIT;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // before any init: all-zero state, zero keystream
    send_word(triv_pkg::REQ_BYTE, rand80(), 8'hA5);
    send_word(triv_pkg::REQ_ADV, rand80(), 8'h00);
    send_word(REQ_UNUSED, rand80(), 8'hFF);
    send_word(triv_pkg::REQ_BYTE, rand80(), 8'hFF);

    // reset key, zero IV
    send_word(triv_pkg::REQ_INIT, '0, 8'h00);
    send_word(triv_pkg::REQ_BYTE, rand80(), 8'h00);
    send_word(triv_pkg::REQ_BYTE, rand80(), 8'hFF);
    send_word(triv_pkg::REQ_ADV, rand80(), 8'h3C);
    send_word(REQ_UNUSED, rand80(), 8'h77);
    send_word(triv_pkg::REQ_BYTE, rand80(), 8'h5A);
    quiesce();

    // new key: old stream goes on until the next init
    write_key('1);
    send_word(triv_pkg::REQ_BYTE, rand80(), 8'h00);
    send_word(triv_pkg::REQ_INIT, '1, 8'h00);
    send_word(triv_pkg::REQ_BYTE, rand80(), 8'h00);
    send_word(triv_pkg::REQ_BYTE, rand80(), 8'hFF);
    send_word(triv_pkg::REQ_ADV, rand80(), 8'h00);
    send_word(triv_pkg::REQ_ADV, rand80(), 8'h00);
    send_word(triv_pkg::REQ_BYTE, rand80(), 8'h80);
    send_word(triv_pkg::REQ_BYTE, rand80(), 8'h01);
    quiesce();

    write_key(rand80());
    send_word(triv_pkg::REQ_INIT, rand80(), 8'h00);
    send_word(triv_pkg::REQ_BYTE, rand80(), 8'($urandom_range(0, 255)));

    // random sessions under several keys
    phase_key[0] = rand80();
    phase_key[1] = {16'h0000, 64'hFFFF_FFFF_FFFF_FFFF};
    phase_key[2] = {16'hFFFF, 64'h0000_0000_0000_0000};
    phase_key[3] = rand80();
    for (int p = 0; p < 4; p++) begin
      quiesce();
      write_key(phase_key[p]);
      n = 0;
      while (n < RANDOM_ITEMS / 4) begin
        // most sessions open with an init; some run on the old stream
        if ($urandom_range(0, 9) != 0) begin
          case ($urandom_range(0, 7))
            0:       iv = '0;
            1:       iv = '1;
            default: iv = rand80();
          endcase
          send_word(triv_pkg::REQ_INIT, iv, 8'($urandom_range(0, 255)));
          n++;
        end
        len = $urandom_range(4, 24);
        repeat (len) begin
          pick = $urandom_range(0, 99);
          if (pick < 80) kind = triv_pkg::REQ_BYTE;
          else if (pick < 92) kind = triv_pkg::REQ_ADV;
          else if (pick < 96) kind = REQ_UNUSED;
          else kind = triv_pkg::REQ_INIT;
          send_word(kind, rand80(), 8'($urandom_range(0, 255)));
        end
        n += len;
      end
    end
    quiesce();

    if (errors == 0 && pending == 0) begin
      $display("trivium_keystream_cipher_top: match");
    end else begin
      $display("trivium_keystream_cipher_top: mismatch");
    end
    $finish;
  end

endmodule
